>>> rtl/stcg_pkg.sv
// Shared types, constants and helpers for the scrolling text column generator.
// No dependencies; stcg_rem, the top module and the testbench import this package.
`default_nettype none

package stcg_pkg;

    // Sizing
    localparam int TEXT_DEPTH  = 256;
    localparam int NUM_GLYPHS  = 128;
    localparam int MAX_HEIGHT  = 16;
    localparam int GLYPH_SLOTS = MAX_HEIGHT + 1;   // rows plus the width slot

    localparam int TEXT_AW  = $clog2(TEXT_DEPTH);
    localparam int GLYPH_AW = $clog2(NUM_GLYPHS);
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);

    // Field widths
    localparam int OPCODE_W   = 3;
    localparam int POS_W      = 8;
    localparam int ROW_W      = 5;
    localparam int VALUE_W    = 8;
    localparam int COL_W      = 16;
    localparam int ID_W       = 7;
    localparam int LEN_W      = 9;
    localparam int CH_W       = 5;
    localparam int CO_W       = 3;
    localparam int GW_W       = 4;                 // glyph width 1..8
    localparam int GLYPH_BITS = 8;                 // bits in one glyph row
    localparam int ROWS_OUT   = (MAX_HEIGHT < COL_W) ? MAX_HEIGHT : COL_W;

    // Stream packing
    localparam int S_ROW_LSB = POS_W;
    localparam int S_VAL_LSB = POS_W + ROW_W;
    localparam int S_TDATA_W = ((POS_W + ROW_W + VALUE_W + 7) / 8) * 8;
    localparam int S_TUSER_W = OPCODE_W + 1;
    localparam int M_TDATA_W = ((COL_W + POS_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 1;

    // Config port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = LEN_W;
    localparam logic [CFG_AW-1:0] CFG_TEXT_OFFSET = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_TEXT_LENGTH = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_CHAR_HEIGHT = 2'd2;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_WRITE_TEXT   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_WRITE_GLYPH  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_SCROLL_LEFT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SCROLL_RIGHT = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SET_POS      = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEXT0,
        ST_GLYPH0,
        ST_TEXT1,
        ST_GLYPH1,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } t_rem_req;

    // floor(num / den) for num < 8 and den in 1..8, by compare against multiples
    function automatic logic [CO_W-1:0] small_quot(input logic [CO_W-1:0] num,
                                                   input logic [GW_W-1:0] den);
        logic [CO_W-1:0] q;
        q = '0;
        for (int j = 1; j < (1 << CO_W); j++) begin
            if (j * int'(den) <= int'(num)) q = CO_W'(j);
        end
        return q;
    endfunction

endpackage

`default_nettype wire

>>> rtl/stcg_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module stcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/stcg_rem.sv
// Restoring remainder unit, one dividend bit per cycle (position mod length).
// Depends on stcg_pkg.
`default_nettype none

module stcg_rem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  stcg_pkg::t_rem_req        i_req,
    output logic                      o_done,
    output logic [stcg_pkg::LEN_W-1:0] o_rem
);
    import stcg_pkg::*;

    localparam int CNT_W = $clog2(POS_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [LEN_W-1:0] r_rem;
    logic [POS_W-1:0] r_dvd;
    logic [LEN_W-1:0] r_dvs;
    logic [LEN_W:0]   w_trial;
    logic [LEN_W-1:0] n_rem;

    // remainder stays below the divisor, so one subtract per step is enough
    always_comb begin
        w_trial = {r_rem, r_dvd[POS_W-1]};
        if (w_trial >= {1'b0, r_dvs}) begin
            n_rem = LEN_W'(w_trial - {1'b0, r_dvs});
        end else begin
            n_rem = w_trial[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(POS_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[POS_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

>>> rtl/scrolling_text_column_generator_top.sv
// Scrolling text column generator: text store, banked glyph store, scroll sequencer.
// Depends on stcg_pkg, stcg_ram, stcg_rem.
//
// Usage:
//   s_axis carries commands: text writes, glyph row writes, scroll left/right
//   and set position. m_axis carries one column beat per scroll with load_frame
//   set. i_cfg_* writes text_offset, text_length, char_height; the user must
//   write them only while idle, as the block does not enforce it. Writes and set
//   position below the length are taken back to back. A scroll reads the text
//   store, then the glyph banks (all rows in parallel): states TEXT0 and GLYPH0
//   when the column lies in the glyph at the character position, plus TEXT1 and
//   GLYPH1 when it lies in a later glyph (second text/glyph read). The column beat
//   is written into the output register as the final glyph state finishes, and the
//   next command is taken in that same cycle. Set position with position >= length
//   also runs the remainder unit, one dividend bit per cycle.
//   Reset: char_index and column offset 0, text_offset 0, text_length 1,
//   char_height 8; store contents are undefined until written.
//   Stall: a finished beat waits in the output register while the next command
//   is taken; a second column waits in its final stage until the register frees.
`default_nettype none

module scrolling_text_column_generator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // position[7:0], glyph_row[12:8], value[20:13], zero pad
    input  logic [stcg_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // opcode[2:0], load_frame[3]
    input  logic [stcg_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // column_bits[15:0], char_position[23:16]
    output logic [stcg_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // insert_at_right[0]
    output logic [stcg_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    input  logic                            i_cfg_we,
    input  logic [stcg_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [stcg_pkg::CFG_DW-1:0]     i_cfg_wdata
);
    import stcg_pkg::*;

    // Input fields
    logic [OPCODE_W-1:0] w_opcode;
    logic [POS_W-1:0]    w_pos;
    logic [ROW_W-1:0]    w_grow;
    logic [VALUE_W-1:0]  w_value;
    logic                w_load;

    assign w_opcode = s_axis_tuser[OPCODE_W-1:0];
    assign w_load   = s_axis_tuser[OPCODE_W];
    assign w_pos    = s_axis_tdata[POS_W-1:0];
    assign w_grow   = s_axis_tdata[S_ROW_LSB +: ROW_W];
    assign w_value  = s_axis_tdata[S_VAL_LSB +: VALUE_W];

    // Registers
    t_state              r_state, n_state;
    logic [POS_W-1:0]    r_text_offset, n_text_offset;
    logic [LEN_W-1:0]    r_text_length, n_text_length;
    logic [CH_W-1:0]     r_char_height, n_char_height;
    logic [POS_W-1:0]    r_ci, n_ci;
    logic [POS_W-1:0]    r_cim, n_cim;        // r_ci mod length, kept alongside
    logic [CO_W-1:0]     r_co, n_co;
    logic                r_left, n_left;
    logic                r_load, n_load;
    logic [CO_W-1:0]     r_k, n_k;
    logic                r_id_ok;
    logic                r_out_valid, n_out_valid;
    logic [COL_W-1:0]    r_out_bits, n_out_bits;
    logic                r_out_left, n_out_left;
    logic [POS_W-1:0]    r_out_pos, n_out_pos;

    // Datapath
    logic [LEN_W-1:0]      w_len;
    logic [LEN_W-1:0]      w_len_m1;
    logic [LEN_W-1:0]      w_cim_inc;
    logic [HEIGHT_W-1:0]   w_h;
    logic [ID_W-1:0]       w_text_rd;
    logic [GLYPH_BITS-1:0] w_bank_rd [GLYPH_SLOTS];
    logic [GLYPH_BITS-1:0] w_width_raw;
    logic [GW_W-1:0]       w_gw;
    logic [CO_W-1:0]       w_q;
    logic [CO_W-1:0]       w_colm;
    logic [CO_W-1:0]       w_sh;
    logic [CO_W-1:0]       w_co_inc;
    logic                  w_adv;
    logic [COL_W-1:0]      w_bits;
    logic                  w_final;
    logic                  w_finish;
    logic                  w_accept;
    logic [POS_W-1:0]      w_ci_upd;
    logic [POS_W-1:0]      w_cim_upd;
    logic [CO_W-1:0]       w_rd_k;
    logic [TEXT_AW-1:0]    w_text_raddr;
    logic                  w_text_we;
    logic                  w_glyph_we;
    t_rem_req              w_rem_req;
    logic                  w_rem_done;
    logic [LEN_W-1:0]      w_rem;

    assign w_len     = (r_text_length == '0) ? LEN_W'(1) : r_text_length;
    assign w_len_m1  = w_len - 1'b1;
    assign w_cim_inc = {1'b0, r_cim} + 1'b1;

    always_comb begin
        if (r_char_height == '0) begin
            w_h = HEIGHT_W'(1);
        end else if (int'(r_char_height) > MAX_HEIGHT) begin
            w_h = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            w_h = HEIGHT_W'(r_char_height);
        end
    end

    // Memories
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_text_we  = w_accept && (w_opcode == OP_WRITE_TEXT) && (int'(w_pos) < TEXT_DEPTH);
    assign w_glyph_we = w_accept && (w_opcode == OP_WRITE_GLYPH)
                        && (int'(w_pos) < NUM_GLYPHS);

    stcg_ram #(
        .WIDTH (ID_W),
        .DEPTH (TEXT_DEPTH)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (w_text_we),
        .i_waddr (TEXT_AW'(w_pos)),
        .i_wdata (w_value[ID_W-1:0]),
        .i_raddr (w_text_raddr),
        .o_rdata (w_text_rd)
    );

    // One bank per row slot, all read at the glyph id from the text store
    for (genvar b = 0; b < GLYPH_SLOTS; b++) begin : g_bank
        stcg_ram #(
            .WIDTH (GLYPH_BITS),
            .DEPTH (NUM_GLYPHS)
        ) u_glyph_ram (
            .i_clk   (i_clk),
            .i_we    (w_glyph_we && (int'(w_grow) == b)),
            .i_waddr (GLYPH_AW'(w_pos)),
            .i_wdata (w_value),
            .i_raddr (GLYPH_AW'(w_text_rd)),
            .o_rdata (w_bank_rd[b])
        );
    end

    stcg_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rem_req),
        .o_done  (w_rem_done),
        .o_rem   (w_rem)
    );

    // Glyph width and column selection
    assign w_width_raw = w_bank_rd[w_h];

    always_comb begin
        if (!r_id_ok || w_width_raw == '0) begin
            w_gw = GW_W'(1);
        end else if (int'(w_width_raw) > GLYPH_BITS) begin
            w_gw = GW_W'(GLYPH_BITS);
        end else begin
            w_gw = GW_W'(w_width_raw);
        end
    end

    // In ST_GLYPH0 w_q is the glyph step past the character position;
    // in the final stage it is the quotient against the selected glyph.
    assign w_q      = small_quot(r_co, w_gw);
    assign w_colm   = CO_W'(int'(r_co) - int'(w_q) * int'(w_gw));
    assign w_sh     = r_left ? CO_W'(int'(w_gw) - 1 - int'(w_colm)) : w_colm;
    assign w_co_inc = r_co + 1'b1;
    assign w_adv    = (int'(small_quot(w_co_inc, w_gw)) * int'(w_gw)) == int'(w_co_inc);

    always_comb begin
        w_bits = '0;
        for (int r = 0; r < ROWS_OUT; r++) begin
            if (r_id_ok && r < int'(w_h)) begin
                w_bits[r] = w_bank_rd[r][w_sh];
            end
        end
    end

    assign w_final  = ((r_state == ST_GLYPH0) && (w_q == '0)) || (r_state == ST_GLYPH1);
    assign w_finish = w_final && (!r_load || !r_out_valid || m_axis_tready);
    assign s_axis_tready = (r_state == ST_IDLE) || w_finish;

    // Position after a finishing scroll step
    always_comb begin
        w_ci_upd  = r_ci;
        w_cim_upd = r_cim;
        if (w_finish) begin
            if (r_left) begin
                if (!w_adv) begin
                    w_ci_upd = r_cim;
                end else if (r_ci == '1 || w_cim_inc == w_len) begin
                    w_ci_upd = '0;
                end else begin
                    w_ci_upd = w_cim_inc[POS_W-1:0];
                end
                w_cim_upd = w_ci_upd;
            end else if (w_adv) begin
                if (r_ci == '0) begin
                    w_ci_upd  = w_len_m1[POS_W-1:0];
                    w_cim_upd = w_len_m1[POS_W-1:0];
                end else begin
                    w_ci_upd  = r_ci - 1'b1;
                    w_cim_upd = (r_cim == '0) ? w_len_m1[POS_W-1:0] : r_cim - 1'b1;
                end
            end
        end
    end

    // Text read: base (+ glyph step while a scroll is in flight); the base
    // already reflects a finishing step so the next scroll can start at once
    always_comb begin
        w_rd_k = '0;
        if (!w_finish) begin
            case (r_state)
                ST_GLYPH0:           w_rd_k = w_q;
                ST_TEXT1, ST_GLYPH1: w_rd_k = r_k;
                default:             w_rd_k = '0;
            endcase
        end
    end

    assign w_text_raddr = TEXT_AW'(int'(r_text_offset) + int'(w_ci_upd) + int'(w_rd_k));

    // Next state and outputs
    always_comb begin
        n_state       = r_state;
        n_text_offset = r_text_offset;
        n_text_length = r_text_length;
        n_char_height = r_char_height;
        n_ci          = w_ci_upd;
        n_cim         = w_cim_upd;
        n_co          = r_co;
        n_left        = r_left;
        n_load        = r_load;
        n_k           = r_k;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_bits    = r_out_bits;
        n_out_left    = r_out_left;
        n_out_pos     = r_out_pos;
        w_rem_req.start    = 1'b0;
        w_rem_req.dividend = w_pos;
        w_rem_req.divisor  = w_len;

        case (r_state)
            ST_IDLE:   n_state = ST_IDLE;
            ST_TEXT0:  n_state = ST_GLYPH0;
            ST_GLYPH0: begin
                if (w_q != '0) begin
                    n_state = ST_TEXT1;
                    n_k     = w_q;
                end
            end
            ST_TEXT1:  n_state = ST_GLYPH1;
            ST_GLYPH1: n_state = ST_GLYPH1;
            ST_DIV: begin
                if (w_rem_done) begin
                    n_state = ST_IDLE;
                    n_cim   = w_rem[POS_W-1:0];
                end
            end
            default:   n_state = ST_IDLE;
        endcase

        if (w_finish) begin
            n_state = ST_IDLE;
            n_co    = w_adv ? '0 : w_co_inc;
            if (r_load) begin
                n_out_valid = 1'b1;
                n_out_bits  = w_bits;
                n_out_left  = r_left;
                n_out_pos   = w_ci_upd;
            end
        end

        if (w_accept) begin
            case (w_opcode)
                OP_SCROLL_LEFT, OP_SCROLL_RIGHT: begin
                    n_state = ST_TEXT0;
                    n_left  = (w_opcode == OP_SCROLL_LEFT);
                    n_load  = w_load;
                end
                OP_SET_POS: begin
                    n_ci = w_pos;
                    if ({1'b0, w_pos} < w_len) begin
                        n_cim = w_pos;
                    end else begin
                        n_state         = ST_DIV;
                        w_rem_req.start = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TEXT_OFFSET: n_text_offset = i_cfg_wdata[POS_W-1:0];
                CFG_TEXT_LENGTH: begin
                    n_text_length = i_cfg_wdata;
                    n_ci          = '0;
                    n_cim         = '0;
                    n_co          = '0;
                end
                CFG_CHAR_HEIGHT: n_char_height = i_cfg_wdata[CH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_text_offset <= '0;
            r_text_length <= LEN_W'(1);
            r_char_height <= CH_W'(8);
            r_ci          <= '0;
            r_cim         <= '0;
            r_co          <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_text_offset <= n_text_offset;
            r_text_length <= n_text_length;
            r_char_height <= n_char_height;
            r_ci          <= n_ci;
            r_cim         <= n_cim;
            r_co          <= n_co;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left     <= n_left;
        r_load     <= n_load;
        r_k        <= n_k;
        r_id_ok    <= (int'(w_text_rd) < NUM_GLYPHS);
        r_out_bits <= n_out_bits;
        r_out_left <= n_out_left;
        r_out_pos  <= n_out_pos;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_out_pos, r_out_bits});
    assign m_axis_tuser  = r_out_left;

    // Checks
    a_cim_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cim} < w_len)
        else $error("reduced char index not below text length");

    a_finish_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && r_load) |=> r_out_valid)
        else $error("finished column not placed in output register");

    a_rem_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rem_done |-> (r_state == ST_DIV))
        else $error("remainder result outside set-position wait");

endmodule

`default_nettype wire

>>> tb/scrolling_text_column_generator_top_tb.sv
// Testbench for scrolling_text_column_generator_top: stream commands in, column beats out.
// Depends on stcg_pkg and the RTL; a scoreboard class predicts every column beat.
`timescale 1ns / 100ps

module scrolling_text_column_generator_top_tb;
    import stcg_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int SETTLE_CYCLES   = 24;
    localparam int ITEMS_PER_PHASE = 138;
    localparam int NUM_PHASES      = 9;
    localparam int PAD_W           = S_TDATA_W - POS_W - ROW_W - VALUE_W;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic             enters_right;
        logic [POS_W-1:0] char_pos;
    } column_beat_t;

    // Mirrors the text store, font store and scroll position; queues the columns to come.
    class marquee_checker;
        logic [ID_W-1:0]       text_mem [TEXT_DEPTH];
        logic [GLYPH_BITS-1:0] font_mem [NUM_GLYPHS*GLYPH_SLOTS];
        logic [POS_W-1:0]      char_idx;
        logic [CO_W-1:0]       col_off;
        logic [POS_W-1:0]      text_base;
        logic [LEN_W-1:0]      text_len;
        logic [CH_W-1:0]       rows_cfg;
        column_beat_t          expected_columns[$];
        int                    mismatches;

        function new();
            char_idx   = '0;
            col_off    = '0;
            text_base  = '0;
            text_len   = LEN_W'(1);
            rows_cfg   = CH_W'(8);
            mismatches = 0;
        endfunction

        function int glyph_rows();
            if (rows_cfg == '0) return 1;
            if (int'(rows_cfg) > MAX_HEIGHT) return MAX_HEIGHT;
            return int'(rows_cfg);
        endfunction

        // width lives in the row slot just above the last glyph row
        function int glyph_cols(int id);
            int w;
            w = int'(font_mem[id * GLYPH_SLOTS + glyph_rows()]);
            if (w == 0) return 1;
            if (w > GLYPH_BITS) return GLYPH_BITS;
            return w;
        endfunction

        function void write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
            case (addr)
                CFG_TEXT_OFFSET: text_base = data[POS_W-1:0];
                CFG_TEXT_LENGTH: begin
                    text_len = data;
                    char_idx = '0;
                    col_off  = '0;
                end
                CFG_CHAR_HEIGHT: rows_cfg = data[CH_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_command(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                                   logic [ROW_W-1:0] row, logic [VALUE_W-1:0] val,
                                   logic load);
            int len, base, w0, id, w, sh;
            logic left;
            column_beat_t beat;
            case (op)
                OP_WRITE_TEXT: text_mem[pos] = val[ID_W-1:0];
                OP_WRITE_GLYPH: begin
                    if (int'(pos) < NUM_GLYPHS && int'(row) <= MAX_HEIGHT)
                        font_mem[int'(pos) * GLYPH_SLOTS + int'(row)] = val;
                end
                OP_SET_POS: char_idx = pos;
                OP_SCROLL_LEFT, OP_SCROLL_RIGHT: begin
                    left = (op == OP_SCROLL_LEFT);
                    len  = (text_len == '0) ? 1 : int'(text_len);
                    base = int'(text_base) + int'(char_idx);
                    // offset past the first glyph's width selects a later character
                    w0   = glyph_cols(int'(text_mem[base % TEXT_DEPTH]));
                    id   = int'(text_mem[(base + int'(col_off) / w0) % TEXT_DEPTH]);
                    w    = glyph_cols(id);
                    sh   = left ? (w - 1 - int'(col_off) % w) : (int'(col_off) % w);
                    beat = '0;
                    for (int r = 0; r < glyph_rows(); r++)
                        beat.column[r] = font_mem[id * GLYPH_SLOTS + r][sh];
                    col_off = col_off + 1'b1;
                    if (int'(col_off) % w == 0) begin
                        col_off = '0;
                        if (left)
                            char_idx = char_idx + 1'b1;
                        else if (char_idx == '0)
                            char_idx = POS_W'(len - 1);
                        else
                            char_idx = char_idx - 1'b1;
                    end
                    if (left) char_idx = POS_W'(int'(char_idx) % len);
                    beat.enters_right = left;
                    beat.char_pos     = char_idx;
                    if (load) expected_columns.push_back(beat);
                end
                default: ;
            endcase
        endfunction

        function void check_column(logic [COL_W-1:0] col, logic right, logic [POS_W-1:0] cpos);
            column_beat_t want;
            if (expected_columns.size() == 0) begin
                $display("%0t: unexpected column beat: column %h right %b char %0d",
                         $time, col, right, cpos);
                mismatches++;
                return;
            end
            want = expected_columns.pop_front();
            if (col !== want.column) begin
                $display("%0t: column_bits expected %h actual %h", $time, want.column, col);
                mismatches++;
            end
            if (right !== want.enters_right) begin
                $display("%0t: insert_at_right expected %b actual %b",
                         $time, want.enters_right, right);
                mismatches++;
            end
            if (cpos !== want.char_pos) begin
                $display("%0t: char_position expected %0d actual %0d", $time, want.char_pos, cpos);
                mismatches++;
            end
        endfunction

        function void close();
            if (expected_columns.size() != 0) begin
                $display("%0t: %0d expected column beats never arrived",
                         $time, expected_columns.size());
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0]     i_cfg_addr    = '0;
    logic [CFG_DW-1:0]     i_cfg_wdata   = '0;

    marquee_checker        sb = new();
    int                    tx_idle = 0;
    int                    rx_idle = 0;
    int unsigned           cycle_count = 0;
    logic [GLYPH_SLOTS-1:0] rows_loaded [NUM_GLYPHS];
    logic                  glyph_ready [NUM_GLYPHS];
    int                    ready_glyphs[$];

    scrolling_text_column_generator_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // position[7:0], glyph_row[12:8], value[20:13]
        .s_axis_tuser  (s_axis_tuser),   // opcode[2:0], load_frame[3]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // column_bits[15:0], char_position[23:16]
        .m_axis_tuser  (m_axis_tuser),   // insert_at_right[0]
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_command(s_axis_tuser[OPCODE_W-1:0], s_axis_tdata[POS_W-1:0],
                            s_axis_tdata[S_ROW_LSB +: ROW_W],
                            s_axis_tdata[S_VAL_LSB +: VALUE_W], s_axis_tuser[OPCODE_W]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_column(m_axis_tdata[COL_W-1:0], m_axis_tuser[0],
                            m_axis_tdata[COL_W +: POS_W]);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [VALUE_W-1:0] font_byte();
        // half the bytes small so that stored widths land in 0..9
        return $urandom_range(1) ? VALUE_W'($urandom) : VALUE_W'($urandom_range(9));
    endfunction

    task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [ROW_W-1:0] row, input logic [VALUE_W-1:0] val,
                            input logic load);
        while ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, val, row, pos};
        s_axis_tuser  <= {load, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // text entries only ever name glyphs whose rows and width slots are all loaded
    task automatic send_text(input logic [POS_W-1:0] addr);
        logic [VALUE_W-1:0] v;
        v[ID_W-1:0]  = ID_W'(ready_glyphs[$urandom_range(ready_glyphs.size() - 1)]);
        v[VALUE_W-1] = 1'($urandom_range(1));
        send_cmd(OP_WRITE_TEXT, addr, ROW_W'($urandom), v, 1'($urandom_range(1)));
    endtask

    task automatic send_glyph_row(input int id, input int row, input logic [VALUE_W-1:0] val);
        if (id < NUM_GLYPHS && row <= MAX_HEIGHT) begin
            rows_loaded[id][row] = 1'b1;
            if (&rows_loaded[id] && !glyph_ready[id]) begin
                glyph_ready[id] = 1'b1;
                ready_glyphs.push_back(id);
            end
        end
        send_cmd(OP_WRITE_GLYPH, POS_W'(id), ROW_W'(row), val, 1'($urandom_range(1)));
    endtask

    task automatic send_scroll(input logic left, input logic load);
        send_cmd(left ? OP_SCROLL_LEFT : OP_SCROLL_RIGHT, POS_W'($urandom),
                 ROW_W'($urandom), VALUE_W'($urandom), load);
    endtask

    task automatic send_set_pos(input logic [POS_W-1:0] pos);
        send_cmd(OP_SET_POS, pos, ROW_W'($urandom), VALUE_W'($urandom), 1'($urandom_range(1)));
    endtask

    task automatic send_unused_op(input int k);
        send_cmd(OPCODE_W'(int'(OP_SET_POS) + k), POS_W'($urandom), ROW_W'($urandom),
                 VALUE_W'($urandom), 1'($urandom_range(1)));
    endtask

    // wait out every pending column plus the remainder unit's worst case
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_columns.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(addr, data);
    endtask

    task automatic program_regs(input logic [2:0] which, input logic [CFG_DW-1:0] off,
                                input logic [CFG_DW-1:0] len, input logic [CFG_DW-1:0] ht);
        if (which[0]) cfg_beat(CFG_TEXT_OFFSET, off);
        if (which[1]) cfg_beat(CFG_TEXT_LENGTH, len);
        if (which[2]) cfg_beat(CFG_CHAR_HEIGHT, ht);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_traffic(input int count);
        int done, pick, run, id, row;
        logic go_left;
        done    = 0;
        run     = 0;
        go_left = 1'b1;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 76) begin
                // runs of one direction walk across glyph and text boundaries
                if (run == 0) begin
                    go_left = 1'($urandom_range(1));
                    run     = $urandom_range(24, 1);
                end
                run--;
                send_scroll(go_left, $urandom_range(9) != 0);
                done++;
            end else if (pick < 83) begin
                send_set_pos($urandom_range(1) ? POS_W'($urandom_range(15)) : POS_W'($urandom));
                done++;
            end else if (pick < 89) begin
                send_text(POS_W'($urandom));
                done++;
            end else if (pick < 97) begin
                if ($urandom_range(3) != 0) begin
                    id  = ready_glyphs[$urandom_range(ready_glyphs.size() - 1)];
                    row = $urandom_range(MAX_HEIGHT);
                end else begin
                    id  = $urandom_range(255);
                    row = $urandom_range(31);
                end
                if (id < NUM_GLYPHS && row <= MAX_HEIGHT) done++;
                send_glyph_row(id, row, font_byte());
            end else begin
                send_unused_op($urandom_range(3, 1));
            end
        end
    endtask

    initial begin
        int id;
        logic [2:0] which;
        logic [CFG_DW-1:0] off, len, ht;

        for (int g = 0; g < NUM_GLYPHS; g++) begin
            rows_loaded[g] = '0;
            glyph_ready[g] = 1'b0;
        end
        tx_idle = 13;
        rx_idle = 45;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // font: glyphs 0..7 and 120..127 cover every id bit; then the whole text store
        for (int g = 0; g < 16; g++) begin
            id = (g < 8) ? g : NUM_GLYPHS - 16 + g;
            for (int r = 0; r <= MAX_HEIGHT; r++) send_glyph_row(id, r, font_byte());
        end
        for (int p = 0; p < TEXT_DEPTH; p++) send_text(POS_W'(p));

        // directed: offset wraps the text address, tallest glyphs
        settle();
        program_regs(3'b111, CFG_DW'(254), CFG_DW'(3), CFG_DW'(MAX_HEIGHT));
        send_cmd(OP_WRITE_TEXT, POS_W'(255), ROW_W'(31), VALUE_W'(8'hFF), 1'b1);
        send_cmd(OP_WRITE_TEXT, POS_W'(0), ROW_W'(0), VALUE_W'(0), 1'b0);
        send_glyph_row(NUM_GLYPHS - 1, MAX_HEIGHT, VALUE_W'(0));     // zero width
        send_glyph_row(0, MAX_HEIGHT, VALUE_W'(8'hFF));              // width above 8
        send_glyph_row(0, 0, VALUE_W'(8'hFF));
        send_glyph_row(255, 3, font_byte());                         // id out of range
        send_glyph_row(3, 31, font_byte());                          // row out of range
        send_glyph_row(NUM_GLYPHS - 1, MAX_HEIGHT + 1, font_byte());
        send_set_pos(POS_W'(255));                                   // beyond the length
        send_scroll(1'b1, 1'b1);
        send_scroll(1'b0, 1'b1);
        send_scroll(1'b0, 1'b0);
        send_set_pos(POS_W'(0));
        send_scroll(1'b0, 1'b1);
        send_scroll(1'b0, 1'b1);
        send_scroll(1'b0, 1'b1);
        for (int k = 1; k <= 3; k++) send_unused_op(k);
        send_scroll(1'b1, 1'b0);
        send_scroll(1'b1, 1'b1);
        send_scroll(1'b1, 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            if (ph == 3) begin
                tx_idle = 45;
                rx_idle = 13;
            end else if (ph == 6) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            which = 3'b111;
            case (ph)
                0: begin off = CFG_DW'(0);   len = CFG_DW'(1);   ht = CFG_DW'(8);  end
                1: begin off = CFG_DW'(255); len = CFG_DW'(256); ht = CFG_DW'(16); end
                2: begin off = CFG_DW'(0);   len = CFG_DW'(0);   ht = CFG_DW'(0);  end
                3: begin off = CFG_DW'(200); len = CFG_DW'(511); ht = CFG_DW'(31); end
                4: begin off = CFG_DW'(17);  len = CFG_DW'(2);   ht = CFG_DW'(1);  end
                default: begin
                    which = 3'($urandom);
                    off   = CFG_DW'($urandom_range(255));
                    len   = $urandom_range(1) ? CFG_DW'($urandom_range(12, 1))
                                              : CFG_DW'($urandom);
                    ht    = $urandom_range(3) != 0 ? CFG_DW'($urandom_range(MAX_HEIGHT, 1))
                                                   : CFG_DW'($urandom_range(31));
                end
            endcase
            program_regs(which, off, len, ht);
            random_traffic(ITEMS_PER_PHASE);
        end

        settle();
        sb.close();
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
rtl/stcg_pkg.sv
rtl/stcg_ram.sv
rtl/stcg_rem.sv
rtl/scrolling_text_column_generator_top.sv
tb/scrolling_text_column_generator_top_tb.sv
